/* sv/min_heap_sort_descending_defines.svh */
// Assertion macros shared by the RTL of the heap sorter.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef MIN_HEAP_SORT_DESCENDING_DEFINES_SVH
`define MIN_HEAP_SORT_DESCENDING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/mhs_pkg.sv */
// Shared types and constants of the heap sorter.
// No dependencies; used by the top level.
`default_nettype none

package mhs_pkg;

   localparam int VALUE_W       = 32;
   localparam int DEPTH_DEFAULT = 64;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

`default_nettype wire

/* sv/mhs_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with a registered read.
// No dependencies.
`default_nettype none

module mhs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/min_heap_sort_descending.sv */
// Loading takes one item per cycle; the final item starts a sort made of sifts over the
// levels of the heap, after which the results are read out of the store one at a time.
// Throughput is set by the sift loop on the single read port of the store.
// One set is handled at a time: no item is taken from the sort until the last result leaves.
// Reset (synchronous, active high) clears the control state, the element count and the
// overflow flag; the store contents stay undefined, since only written entries are read.
`default_nettype none

`include "min_heap_sort_descending_defines.svh"

module min_heap_sort_descending #(
   parameter int DEPTH = mhs_pkg::DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input channel: one element per item.
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire mhs_pkg::value_type req_value,
   input  wire logic               req_final_item,
   // Result channel: the elements in descending order.
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output mhs_pkg::value_type      rsp_sorted_value,
   output logic                    rsp_run_end,
   output logic                    rsp_overflow
);

   // Address width of the store, width of a count that can hold DEPTH itself, and a
   // wider index for child positions, which can run to twice the depth.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + 1;

   // Sequencer states.
   localparam logic [3:0] S_LOAD       = 4'd0;
   localparam logic [3:0] S_BUILD_NEXT = 4'd1;
   localparam logic [3:0] S_SIFT_LOAD  = 4'd2;
   localparam logic [3:0] S_SIFT       = 4'd3;
   localparam logic [3:0] S_SIFT_L     = 4'd4;
   localparam logic [3:0] S_SIFT_R     = 4'd5;
   localparam logic [3:0] S_SIFT_CMP   = 4'd6;
   localparam logic [3:0] S_EXT_NEXT   = 4'd7;
   localparam logic [3:0] S_EXT_RDK    = 4'd8;
   localparam logic [3:0] S_EXT_SWAP   = 4'd9;
   localparam logic [3:0] S_OUT_RD     = 4'd10;
   localparam logic [3:0] S_OUT_CAP    = 4'd11;
   localparam logic [3:0] S_OUT_WAIT   = 4'd12;

   // Control state.
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;     // elements held in the store
   logic          overflow_ff, overflow_in;
   logic [CW-1:0] n_ff, n_in;             // size of the set being sorted
   logic [CW-1:0] k_ff, k_in;             // build: parents left; extraction: unsorted tail
   logic [CW-1:0] limit_ff, limit_in;     // heap size of the current sift
   logic          phase_ext_ff, phase_ext_in;
   logic [AW-1:0] p_ff, p_in;             // hole position of the current sift
   logic [AW-1:0] cidx_ff, cidx_in;       // smaller child found so far
   logic [AW-1:0] i_ff, i_in;             // output position
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   mhs_pkg::value_type pval_ff, pval_in;  // value carried down by the sift
   mhs_pkg::value_type cval_ff, cval_in;  // smaller child value, or the old root
   mhs_pkg::value_type rsp_value_ff, rsp_value_in;
   logic               rsp_run_end_ff, rsp_run_end_in;
   logic               rsp_overflow_ff, rsp_overflow_in;

   // Store ports.
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   mhs_pkg::value_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   mhs_pkg::value_type rd_data;

   logic          req_accept;
   logic          store_full;
   logic [CW-1:0] count_next;
   logic [XW-1:0] c_left;
   logic [XW-1:0] c_right;
   logic          has_left;
   logic          has_right;

   // The heap store. Every entry is written before it is read, and a read never
   // addresses the entry written in the same cycle, so no forwarding is needed.
   mhs_ram #(
      .WIDTH (mhs_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Items are taken only while loading; the sort and the output run undisturbed.
   assign req_stall  = (state_ff != S_LOAD);
   assign req_accept = req_valid && !req_stall;

   assign store_full = (count_ff == CW'(DEPTH));
   assign count_next = store_full ? count_ff : count_ff + CW'(1);

   // Children of the hole, compared against the heap size in a wider index.
   assign c_left    = XW'({p_ff, 1'b0}) + XW'(1);
   assign c_right   = c_left + XW'(1);
   assign has_left  = (c_left < XW'(limit_ff));
   assign has_right = (c_right < XW'(limit_ff));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      overflow_in     = overflow_ff;
      n_in            = n_ff;
      k_in            = k_ff;
      limit_in        = limit_ff;
      phase_ext_in    = phase_ext_ff;
      p_in            = p_ff;
      cidx_in         = cidx_ff;
      i_in            = i_ff;
      rsp_valid_in    = rsp_valid_ff;
      pval_in         = pval_ff;
      cval_in         = cval_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_run_end_in  = rsp_run_end_ff;
      rsp_overflow_in = rsp_overflow_ff;
      wr_en           = 1'b0;
      wr_addr         = p_ff;
      wr_data         = pval_ff;
      rd_en           = 1'b0;
      rd_addr         = p_ff;

      unique case (state_ff)
         S_LOAD: begin
            // Store the element, or drop it and remember the overflow when full.
            if (req_accept) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  wr_data = req_value;
               end
               count_in = count_next;
               if (req_final_item) begin
                  // The build phase walks the parents from n/2 - 1 down to the root.
                  n_in         = count_next;
                  k_in         = count_next >> 1;
                  phase_ext_in = 1'b0;
                  state_in     = S_BUILD_NEXT;
               end
            end
         end

         S_BUILD_NEXT: begin
            if (k_ff == '0) begin
               // Heap is built; extraction works on the unsorted prefix of n - 1 down to 1.
               k_in         = n_ff - CW'(1);
               phase_ext_in = 1'b1;
               state_in     = S_EXT_NEXT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(k_ff - CW'(1));
               p_in     = AW'(k_ff - CW'(1));
               limit_in = n_ff;
               k_in     = k_ff - CW'(1);
               state_in = S_SIFT_LOAD;
            end
         end

         S_SIFT_LOAD: begin
            pval_in  = rd_data;
            state_in = S_SIFT;
         end

         S_SIFT: begin
            if (has_left) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(c_left);
               state_in = S_SIFT_L;
            end else begin
               // Leaf reached: drop the carried value into the hole.
               wr_en    = 1'b1;
               state_in = phase_ext_ff ? S_EXT_NEXT : S_BUILD_NEXT;
            end
         end

         S_SIFT_L: begin
            cval_in = rd_data;
            cidx_in = AW'(c_left);
            if (has_right) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(c_right);
               state_in = S_SIFT_R;
            end else begin
               state_in = S_SIFT_CMP;
            end
         end

         S_SIFT_R: begin
            // The right child wins only when strictly smaller.
            if (cval_ff > rd_data) begin
               cval_in = rd_data;
               cidx_in = AW'(c_right);
            end
            state_in = S_SIFT_CMP;
         end

         S_SIFT_CMP: begin
            wr_en = 1'b1;
            if (pval_ff <= cval_ff) begin
               state_in = phase_ext_ff ? S_EXT_NEXT : S_BUILD_NEXT;
            end else begin
               // Move the child up into the hole and follow it down.
               wr_data  = cval_ff;
               p_in     = cidx_ff;
               state_in = S_SIFT;
            end
         end

         S_EXT_NEXT: begin
            if (k_ff == '0) begin
               i_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_EXT_RDK;
            end
         end

         S_EXT_RDK: begin
            cval_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(k_ff);
            state_in = S_EXT_SWAP;
         end

         S_EXT_SWAP: begin
            // The minimum goes to the tail; the old tail value sifts down from the root.
            pval_in  = rd_data;
            wr_en    = 1'b1;
            wr_addr  = AW'(k_ff);
            wr_data  = cval_ff;
            p_in     = '0;
            limit_in = k_ff;
            k_in     = k_ff - CW'(1);
            state_in = S_SIFT;
         end

         S_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = S_OUT_CAP;
         end

         S_OUT_CAP: begin
            rsp_value_in    = rd_data;
            rsp_run_end_in  = (CW'(i_ff) + CW'(1) == n_ff);
            rsp_overflow_in = overflow_ff;
            rsp_valid_in    = 1'b1;
            state_in        = S_OUT_WAIT;
         end

         S_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_run_end_ff) begin
                  // Run complete: the store is free for the next set.
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = S_LOAD;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         limit_ff     <= '0;
         phase_ext_ff <= 1'b0;
         p_ff         <= '0;
         cidx_ff      <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         limit_ff     <= limit_in;
         phase_ext_ff <= phase_ext_in;
         p_ff         <= p_in;
         cidx_ff      <= cidx_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pval_ff         <= pval_in;
      cval_ff         <= cval_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_run_end_ff  <= rsp_run_end_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_run_end      = rsp_run_end_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   // The element count never passes the store depth.
   `MHS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "element count above depth")
   // A read never targets the entry that is being written in the same cycle.
   `MHS_ASSERT_SAME(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr, "store read/write clash")
   // The chosen child always lies inside the heap of the current sift.
   `MHS_ASSERT_SAME(a_child_in_heap, state_ff == S_SIFT_CMP, CW'(cidx_ff) < limit_ff,
      "sift child outside heap")
   // Taking the last result of a run leaves the block empty and loading.
   `MHS_ASSERT_NEXT(a_run_clears, rsp_valid && !rsp_stall && rsp_run_end,
      count_ff == '0 && !overflow_ff && state_ff == S_LOAD, "run end did not clear state")
   // No new item is taken while a result is on offer.
   `MHS_ASSERT_SAME(a_no_load_on_rsp, rsp_valid_ff, req_stall, "input taken during output")

endmodule

`default_nettype wire

/* tb/sv/tb_min_heap_sort_descending.sv */
// Self-checking testbench for min_heap_sort_descending: it offers sets of signed elements,
// predicts the descending output with its own heap sort and checks every result item.
// Depends on mhs_pkg and the RTL of min_heap_sort_descending only.
module tb_min_heap_sort_descending;
   timeunit 1ns;
   timeprecision 1ps;

   typedef mhs_pkg::value_type value_type;

   // The store holds this many elements; anything beyond it is dropped and flagged.
   localparam int STORE_DEPTH = mhs_pkg::DEPTH_DEFAULT;
   // A full sort runs with nothing moving on either side, so the watchdog limit sits well
   // above its length plus the long receiver hold-off.
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_ELEMENTS = 16;

   localparam value_type VALUE_MIN = value_type'(32'h8000_0000);
   localparam value_type VALUE_MAX = value_type'(32'h7FFF_FFFF);

   typedef struct {
      value_type value;
      logic      run_end;
      logic      overflow;
   } sorted_entry_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   value_type req_value = '0;
   logic      req_final_item = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   value_type rsp_sorted_value;
   logic      rsp_run_end;
   logic      rsp_overflow;

   always #5 clock = ~clock;

   min_heap_sort_descending #(
      .DEPTH(STORE_DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_final_item  (req_final_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_run_end     (rsp_run_end),
      .rsp_overflow    (rsp_overflow)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor state: our own copy of the store, the element count and the drop flag.
   // Only entries below the count are ever read, so the store needs no reset.
   // ---------------------------------------------------------------------------------------
   value_type        held_values [STORE_DEPTH];
   int unsigned      held_count = 0;
   bit               held_overflow = 1'b0;
   sorted_entry_type sorted_outputs_due [$];

   int unsigned elements_offered = 0;
   int unsigned sets_closed = 0;
   int unsigned overflow_sets = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;

   // Handshake between the pressure test and the receiver process.
   bit          hold_off_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_phase_left = 0;
   int unsigned stall_percent = 0;
   int unsigned burst_left = 0;

   // Moves the element at top toward the leaves until both children are no smaller,
   // looking only at the first limit entries. The parent wins a tie with the smaller
   // child, which matches the min-heap order the block keeps.
   function automatic void sift_toward_leaves(int unsigned limit, int unsigned top);
      int unsigned parent;
      int unsigned child;
      value_type   tmp;
      bit          settled;
      parent = top;
      child = parent * 2 + 1;
      settled = 1'b0;
      while (child < limit && !settled) begin
         if (child + 1 < limit && held_values[child] > held_values[child + 1])
            child = child + 1;
         if (held_values[parent] <= held_values[child]) begin
            settled = 1'b1;
         end else begin
            tmp = held_values[parent];
            held_values[parent] = held_values[child];
            held_values[child] = tmp;
            parent = child;
            child = parent * 2 + 1;
         end
      end
   endfunction

   // Stores or drops one accepted element. A final element closes the set: the held
   // elements are heap sorted into descending order and queued as due results.
   function automatic void absorb_element(value_type v, logic fin);
      int               k;
      int unsigned      n;
      value_type        tmp;
      sorted_entry_type entry;
      if (held_count < STORE_DEPTH) begin
         held_values[held_count] = v;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (fin) begin
         n = held_count;
         if (n >= 2) begin
            // Build the min-heap from the last parent back to the root.
            for (k = (n - 2) / 2; k >= 0; k--)
               sift_toward_leaves(n, k);
            // Each pass parks the current minimum just past the shrinking heap.
            for (k = n - 1; k > 0; k--) begin
               tmp = held_values[0];
               held_values[0] = held_values[k];
               held_values[k] = tmp;
               sift_toward_leaves(k, 0);
            end
         end
         for (k = 0; k < n; k++) begin
            entry.value = held_values[k];
            entry.run_end = (k == n - 1);
            entry.overflow = held_overflow;
            sorted_outputs_due.push_back(entry);
         end
         sets_closed++;
         if (held_overflow)
            overflow_sets++;
         held_count = 0;
         held_overflow = 1'b0;
      end
   endfunction

   // Values lean toward the extremes and a narrow band around zero, so that equal
   // elements show up often, while plain random words toggle every bit.
   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2, 3: return value_type'(int'($urandom_range(0, 16)) - 8);
         default: return value_type'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sender. Items go out in bursts of random length with random gaps in between; some
   // bursts follow the previous one with no gap at all. The valid is raised only once per
   // time step and stays up across back-to-back items, so the payload simply changes.
   // ---------------------------------------------------------------------------------------
   task automatic send_element(input value_type v, input logic fin);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      req_final_item <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_element(v, fin);
      elements_offered++;
   endtask

   // Sends a set of the given size with random content, the last element marked final.
   task automatic send_random_set(input int unsigned size);
      int unsigned i;
      for (i = 0; i < size; i++)
         send_element(pick_value(), i == size - 1);
   endtask

   // Drops the valid, then waits until every due result has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sorted_outputs_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver and checker. Results are sampled at the edge, compared field by field with the
   // oldest due entry, and the stall for the next cycle is chosen. The stall follows phases
   // of random length: never, light, half or heavy. A hold-off request overrides the pattern
   // and keeps the stall high for a long stretch.
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input sorted_entry_type due);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected %0d/%0b/%0b, got %0d/%0b/%0b (value/end/ovf)",
                  what, due.value, due.run_end, due.overflow,
                  rsp_sorted_value, rsp_run_end, rsp_overflow);
   endtask

   always @(posedge clock) begin
      sorted_entry_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (sorted_outputs_due.size() == 0) begin
            due = '{value: '0, run_end: 1'b0, overflow: 1'b0};
            report_mismatch("result with nothing due", due);
         end else begin
            due = sorted_outputs_due.pop_front();
            if (rsp_sorted_value !== due.value || rsp_run_end !== due.run_end
                || rsp_overflow !== due.overflow)
               report_mismatch("wrong field", due);
         end
      end
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: stall_percent = 0;
               1: stall_percent = 25;
               2: stall_percent = 50;
               default: stall_percent = 80;
            endcase
         end
         stall_phase_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_percent);
      end
   end

   // Watchdog: any cycle with no item accepted on either side counts toward the limit.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d results still due",
                  IDLE_LIMIT, sorted_outputs_due.size());
         $display("[min_heap_sort_descending] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Small sets: a lone final element at each extreme, a mixed set of extremes and bit
   // patterns, a set of equal values, and both orders of a two-element set.
   task automatic test_directed();
      value_type mixed [9];
      int        i;
      mixed = '{VALUE_MAX, VALUE_MIN, value_type'(0), value_type'(-1), value_type'(1),
                VALUE_MIN + 1, VALUE_MAX - 1, value_type'(32'h5555_5555),
                value_type'(32'hAAAA_AAAA)};
      send_element(VALUE_MIN, 1'b1);
      send_element(VALUE_MAX, 1'b1);
      for (i = 0; i < 9; i++)
         send_element(mixed[i], i == 8);
      for (i = 0; i < 5; i++)
         send_element(value_type'(7), i == 4);
      send_element(value_type'(-3), 1'b0);
      send_element(value_type'(4), 1'b1);
      send_element(value_type'(4), 1'b0);
      send_element(value_type'(-3), 1'b1);
      wait_for_results();
   endtask

   // Exactly a full store, with the final element landing in the last free slot.
   // The first half rises and the rest is random, so the heap has real work to do.
   task automatic test_full_store();
      int i;
      for (i = 0; i < STORE_DEPTH; i++)
         send_element((i < STORE_DEPTH / 2) ? value_type'(i * 3 - 40) : pick_value(),
                      i == STORE_DEPTH - 1);
      wait_for_results();
   endtask

   // Two elements past a full store: one ordinary element is dropped and then the final
   // element itself is dropped, yet it still starts the sort of what is held.
   task automatic test_overflow();
      send_random_set(STORE_DEPTH + 2);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while a set is sorted and a second set is
   // already offered, so the block has to keep its input stalled until the results drain.
   task automatic test_backpressure();
      hold_off_request = 1'b1;
      send_random_set(12);
      send_random_set(6);
      wait_for_results();
   endtask

   // Random sets, mostly small, now and then large, rarely past the store's capacity.
   task automatic test_random();
      int unsigned start;
      int unsigned size;
      int unsigned pick;
      start = elements_offered;
      while (elements_offered - start < RANDOM_ELEMENTS) begin
         pick = $urandom_range(0, 29);
         if (pick == 0)
            size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
         else if (pick <= 2)
            size = $urandom_range(20, STORE_DEPTH);
         else
            size = $urandom_range(1, 12);
         send_random_set(size);
      end
      wait_for_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_store();
      test_overflow();
      test_backpressure();
      test_random();

      repeat (50) @(posedge clock);
      $display("Covered %0d sets (%0d with dropped elements) from %0d offered elements,",
               sets_closed, overflow_sets, elements_offered);
      $display("checking %0d sorted results under random gaps, stalls and one long hold-off.",
               results_checked);
      if (mismatch_count == 0 && sorted_outputs_due.size() == 0) begin
         $display("[min_heap_sort_descending] OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, sorted_outputs_due.size());
         $display("[min_heap_sort_descending] ERROR");
      end
      $finish;
   end

endmodule
